FILE: hw/rtl/avs_pkg.sv
package avs_pkg;

	localparam int CODE_BITS = 10;
	localparam int ACC_W     = 64;
	localparam int INT_W     = 32;
	localparam int N_CELLS   = 4;
	localparam int SPLIT_CODE = 194;

	localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh4000_0000_0000_0000;

	// range numbers
	localparam logic [2:0] RNG_500MV = 3'd0;
	localparam logic [2:0] RNG_1V    = 3'd1;
	localparam logic [2:0] RNG_10V   = 3'd2;
	localparam logic [2:0] RNG_100MV = 3'd3;
	localparam logic [2:0] RNG_5V    = 3'd5;

	// suggestion thresholds in mV, taken on the range 2 reading
	localparam logic signed [INT_W-1:0] SUG_LIM_100MV = 32'sd80;
	localparam logic signed [INT_W-1:0] SUG_LIM_500MV = 32'sd400;
	localparam logic signed [INT_W-1:0] SUG_LIM_1V    = 32'sd800;
	localparam logic signed [INT_W-1:0] SUG_LIM_5V    = 32'sd4000;

	typedef struct packed {
		logic [CODE_BITS-1:0]    x;
		logic [2:0]              rng;
		logic                    hi;
		logic signed [ACC_W-1:0] lin;
	} avs_tag_t;

	function automatic logic signed [ACC_W-1:0] lin_gain(input logic [2:0] rng);
		logic signed [ACC_W-1:0] g;
		case (rng)
			RNG_500MV: g = 64'sd2276440041;
			RNG_1V:    g = 64'sd4213083745;
			RNG_100MV: g = 64'sd464930210;
			RNG_5V:    g = 64'sd30922390142;
			default:   g = '0;
		endcase
		return g;
	endfunction

	function automatic logic signed [ACC_W-1:0] lin_off(input logic [2:0] rng);
		logic signed [ACC_W-1:0] o;
		case (rng)
			RNG_500MV: o = -64'sd114609913804;
			RNG_1V:    o = -64'sd209744298403;
			RNG_100MV: o = -64'sd22374331481;
			RNG_5V:    o = -64'sd1501932883542;
			default:   o = '0;
		endcase
		return o;
	endfunction

	// quartic coefficients, highest power first
	function automatic logic signed [ACC_W-1:0] quart_coef(input logic [2:0] idx,
			input logic hi);
		logic signed [ACC_W-1:0] c;
		if (!hi) begin
			case (idx)
				3'd0:    c = -64'sd2862;
				3'd1:    c = 64'sd1546751;
				3'd2:    c = -64'sd384838948;
				3'd3:    c = 64'sd123411160787;
				3'd4:    c = -64'sd5464229192663;
				default: c = '0;
			endcase
		end else begin
			case (idx)
				3'd0:    c = 64'sd208;
				3'd1:    c = -64'sd379603;
				3'd2:    c = 64'sd177450869;
				3'd3:    c = 64'sd56403228518;
				3'd4:    c = -64'sd4291496962425;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic signed [INT_W-1:0] full_scale(input logic [2:0] rng);
		logic signed [INT_W-1:0] f;
		case (rng)
			RNG_500MV: f = 32'sd500;
			RNG_1V:    f = 32'sd1000;
			RNG_10V:   f = 32'sd10000;
			RNG_100MV: f = 32'sd100;
			RNG_5V:    f = 32'sd5000;
			default:   f = '0;
		endcase
		return f;
	endfunction

	// q32 to integer, truncated toward zero
	function automatic logic signed [INT_W-1:0] q32_trunc(input logic signed [ACC_W-1:0] q);
		logic signed [INT_W-1:0] ip;
		ip = q[ACC_W-1:ACC_W-INT_W];
		if (q[ACC_W-1] && (q[ACC_W-INT_W-1:0] != '0))
			ip = ip + 32'sd1;
		return ip;
	endfunction

endpackage

FILE: hw/rtl/avs_mac_cell.sv
module avs_mac_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_i,
	input  avs_pkg::avs_tag_t                 tag_i,
	input  logic signed [avs_pkg::ACC_W-1:0]  acc_i,
	input  logic signed [avs_pkg::ACC_W-1:0]  coef_i,
	output logic                              valid_o,
	output avs_pkg::avs_tag_t                 tag_o,
	output logic signed [avs_pkg::ACC_W-1:0]  acc_o
);

	localparam int PW = avs_pkg::ACC_W + avs_pkg::CODE_BITS + 1;
	localparam logic signed [PW-1:0] PLIM = PW'(avs_pkg::ACC_LIM);
	localparam logic signed [avs_pkg::ACC_W:0] SLIM = (avs_pkg::ACC_W+1)'(avs_pkg::ACC_LIM);

	logic signed [PW-1:0]              acc_w;
	logic signed [PW-1:0]              x_w;
	logic signed [PW-1:0]              prod_full;
	logic signed [avs_pkg::ACC_W-1:0]  prod_sat;
	logic signed [avs_pkg::ACC_W:0]    sum;
	logic signed [avs_pkg::ACC_W-1:0]  sum_sat;

	logic                              valid_s1;
	avs_pkg::avs_tag_t                 tag_s1;
	logic signed [avs_pkg::ACC_W-1:0]  prod_s1;
	logic signed [avs_pkg::ACC_W-1:0]  coef_s1;
	logic                              valid_s2;
	avs_pkg::avs_tag_t                 tag_s2;
	logic signed [avs_pkg::ACC_W-1:0]  acc_s2;

	// multiply, clamped to the accumulator limit
	always_comb begin
		acc_w     = PW'(acc_i);
		x_w       = PW'($signed({1'b0, tag_i.x}));
		prod_full = acc_w * x_w;
		if (prod_full > PLIM)
			prod_sat = avs_pkg::ACC_LIM;
		else if (prod_full < -PLIM)
			prod_sat = -avs_pkg::ACC_LIM;
		else
			prod_sat = prod_full[avs_pkg::ACC_W-1:0];
	end

	always_comb begin
		sum = (avs_pkg::ACC_W+1)'(prod_s1) + (avs_pkg::ACC_W+1)'(coef_s1);
		if (sum > SLIM)
			sum_sat = avs_pkg::ACC_LIM;
		else if (sum < -SLIM)
			sum_sat = -avs_pkg::ACC_LIM;
		else
			sum_sat = sum[avs_pkg::ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_i;
		prod_s1 <= prod_sat;
		coef_s1 <= coef_i;
		tag_s2  <= tag_s1;
		acc_s2  <= sum_sat;
	end

	assign valid_o = valid_s2;
	assign tag_o   = tag_s2;
	assign acc_o   = acc_s2;

	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (acc_s2 <= avs_pkg::ACC_LIM) && (acc_s2 >= -avs_pkg::ACC_LIM))
		else $error("accumulator beyond limit");

	a_prod_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (prod_s1 <= avs_pkg::ACC_LIM) && (prod_s1 >= -avs_pkg::ACC_LIM))
		else $error("product beyond limit");

	a_two_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_i |-> ##2 valid_o)
		else $error("cell lost an item");

endmodule

FILE: hw/rtl/autorange_voltmeter_scaler.sv
// Converts one averaged converter code and a range number into millivolts, an
// in-range flag and a suggested range. A command is taken on every clock edge
// with start high; busy is always low, so one command per cycle is sustained.
// Each result appears for one cycle with done high, once its command has passed
// through four two-stage Horner cells for the range 2 quartic, a truncation
// stage and the output register; the linear ranges run in a side cell alongside
// the first Horner cell. The receiver cannot stall the output, so results must be
// taken as they come.
module autorange_voltmeter_scaler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [avs_pkg::CODE_BITS-1:0]     adc_code,
	input  logic [2:0]                        range_select,
	output logic                              done,
	output logic signed [15:0]                millivolts,
	output logic                              within_range,
	output logic [2:0]                        suggested_range
);

	localparam int NC = avs_pkg::N_CELLS;

	logic                              accept;
	avs_pkg::avs_tag_t                 tag_port;
	logic signed [avs_pkg::ACC_W-1:0]  lin_acc;

	logic                              vld_in  [NC];
	logic                              vld_out [NC];
	avs_pkg::avs_tag_t                 tag_in  [NC];
	avs_pkg::avs_tag_t                 tag_out [NC];
	logic signed [avs_pkg::ACC_W-1:0]  acc_in  [NC];
	logic signed [avs_pkg::ACC_W-1:0]  acc_out [NC];
	logic signed [avs_pkg::ACC_W-1:0]  coef_in [NC];

	logic                              vld_s9;
	logic [2:0]                        rng_s9;
	logic                              cal_s9;
	logic signed [avs_pkg::INT_W-1:0]  mv_s9;
	logic signed [avs_pkg::INT_W-1:0]  r_s9;

	logic                              done_q;
	logic signed [15:0]                mv_q;
	logic                              within_q;
	logic [2:0]                        sug_q;

	logic signed [avs_pkg::INT_W-1:0]  q_int;
	logic signed [avs_pkg::INT_W-1:0]  l_int;
	logic signed [avs_pkg::INT_W-1:0]  mv_sel;
	logic                              cal_sel;
	logic signed [15:0]                mv_sat;
	logic [2:0]                        sug;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		tag_port.x   = adc_code;
		tag_port.rng = range_select;
		tag_port.hi  = adc_code > avs_pkg::CODE_BITS'(avs_pkg::SPLIT_CODE);
		tag_port.lin = '0;
	end

	// linear ranges: one multiply-add, joins the tag ahead of the second cell
	avs_mac_cell u_lin_cell (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (accept),
		.tag_i   (tag_port),
		.acc_i   (avs_pkg::lin_gain(range_select)),
		.coef_i  (avs_pkg::lin_off(range_select)),
		.valid_o (),
		.tag_o   (),
		.acc_o   (lin_acc)
	);

	always_comb begin
		vld_in[0]  = accept;
		tag_in[0]  = tag_port;
		acc_in[0]  = avs_pkg::quart_coef(3'd0, tag_port.hi);
		coef_in[0] = avs_pkg::quart_coef(3'd1, tag_port.hi);
		for (int k = 1; k < NC; k++) begin
			vld_in[k] = vld_out[k-1];
			tag_in[k] = tag_out[k-1];
			acc_in[k] = acc_out[k-1];
		end
		tag_in[1].lin = lin_acc;
		for (int k = 1; k < NC; k++)
			coef_in[k] = avs_pkg::quart_coef(3'(k + 1), tag_in[k].hi);
	end

	for (genvar g = 0; g < NC; g++) begin : g_horner
		avs_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (vld_in[g]),
			.tag_i   (tag_in[g]),
			.acc_i   (acc_in[g]),
			.coef_i  (coef_in[g]),
			.valid_o (vld_out[g]),
			.tag_o   (tag_out[g]),
			.acc_o   (acc_out[g])
		);
	end

	// truncate and pick the reading for the selected range
	always_comb begin
		q_int = avs_pkg::q32_trunc(acc_out[NC-1]);
		l_int = avs_pkg::q32_trunc(tag_out[NC-1].lin);
		if (tag_out[NC-1].rng inside {avs_pkg::RNG_500MV, avs_pkg::RNG_1V,
				avs_pkg::RNG_100MV, avs_pkg::RNG_5V}) begin
			mv_sel  = l_int;
			cal_sel = 1'b1;
		end else if (tag_out[NC-1].rng == avs_pkg::RNG_10V) begin
			mv_sel  = q_int;
			cal_sel = 1'b1;
		end else begin
			mv_sel  = avs_pkg::INT_W'(tag_out[NC-1].x);
			cal_sel = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else
			vld_s9 <= vld_out[NC-1];
	end

	always_ff @(posedge clk) begin
		rng_s9 <= tag_out[NC-1].rng;
		cal_s9 <= cal_sel;
		mv_s9  <= mv_sel;
		r_s9   <= q_int;
	end

	always_comb begin
		if (mv_s9 > 32'sd32767)
			mv_sat = 16'sh7fff;
		else if (mv_s9 < -32'sd32768)
			mv_sat = 16'sh8000;
		else
			mv_sat = mv_s9[15:0];

		if (r_s9 <= avs_pkg::SUG_LIM_100MV)
			sug = avs_pkg::RNG_100MV;
		else if (r_s9 <= avs_pkg::SUG_LIM_500MV)
			sug = avs_pkg::RNG_500MV;
		else if (r_s9 <= avs_pkg::SUG_LIM_1V)
			sug = avs_pkg::RNG_1V;
		else if (r_s9 <= avs_pkg::SUG_LIM_5V)
			sug = avs_pkg::RNG_5V;
		else
			sug = avs_pkg::RNG_10V;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s9;
	end

	always_ff @(posedge clk) begin
		mv_q     <= mv_sat;
		within_q <= cal_s9 && (mv_s9 <= avs_pkg::full_scale(rng_s9));
		sug_q    <= sug;
	end

	assign done            = done_q;
	assign millivolts      = mv_q;
	assign within_range    = within_q;
	assign suggested_range = sug_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##10 done)
		else $error("result not delivered ten cycles after transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s9))
		else $error("result without a command");

	a_sug_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (suggested_range == avs_pkg::RNG_100MV) ||
			(suggested_range == avs_pkg::RNG_500MV) ||
			(suggested_range == avs_pkg::RNG_1V) ||
			(suggested_range == avs_pkg::RNG_5V) ||
			(suggested_range == avs_pkg::RNG_10V))
		else $error("suggested range is not a calibrated range");

endmodule
